// File: hdl/chlg_pkg.sv
// ----------------------------------------------------------------------------
// chlg_pkg
// Types, constants and register layout shared by the hotplug load governor.
// ----------------------------------------------------------------------------
package chlg_pkg;

    localparam int NUM_CORES   = 4;
    localparam int MAX_HISTORY = 16;
    localparam int NUM_LEVELS  = 5;

    localparam int LOAD_W     = 12;
    localparam int CORE_W     = 4;
    localparam int HLEN_W     = 5;
    localparam int LOCK_W     = 16;
    localparam int THR_W      = LOAD_W * 5;
    localparam int HIST_IDX_W = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int NLEN_W     = HIST_IDX_W + 1;
    localparam int SUM_W      = LOAD_W + HIST_IDX_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int CNT_W      = (HIST_IDX_W > DIV_CNT_W) ? HIST_IDX_W : DIV_CNT_W;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int APB_DATA_W = 64;
    localparam int PADDR_W    = 6;

    localparam logic [CORE_W-1:0] NUM_CORES_C = CORE_W'(NUM_CORES);

    localparam logic [CORE_W-1:0] MIN_CORES_RST   = 4'd1;
    localparam logic [CORE_W-1:0] MAX_CORES_RST   = 4'd4;
    localparam logic [CORE_W-1:0] BOOST_CORES_RST = 4'd2;
    localparam logic [HLEN_W-1:0] HIST_LEN_RST    = 5'd10;
    localparam logic [LOCK_W-1:0] LOCK_DUR_RST    = 16'd2000;
    localparam logic [THR_W-1:0]  UP_THR_RST      = 60'd115415050050806160;
    localparam logic [THR_W-1:0]  DOWN_THR_RST    = 60'd39411994968719360;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_TICK    = 2'd1,
        OP_SCR_OFF = 2'd2,
        OP_SCR_ON  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2,
        ACT_HELD = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        REG_MIN_CORES   = 3'd0,
        REG_MAX_CORES   = 3'd1,
        REG_BOOST_CORES = 3'd2,
        REG_HIST_LEN    = 3'd3,
        REG_LOCK_DUR    = 3'd4,
        REG_UP_THR      = 3'd5,
        REG_DOWN_THR    = 3'd6
    } reg_idx_t;

    // How the back end handles an item, settled at accept time
    typedef enum logic [2:0] {
        K_PIN_MIN,
        K_PIN_MAX,
        K_BOOST,
        K_BANDS,
        K_TICK,
        K_SCR_OFF,
        K_SCR_ON
    } kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WRITE,
        B_SUM,
        B_DIV,
        B_DECIDE
    } b_state_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [LOAD_W-1:0] load_sample;
        logic [CORE_W-1:0] online_count;
        logic              boost_request;
    } req_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [CORE_W-1:0] target_cores;
        logic [LOAD_W-1:0] average_load;
    } rsp_t;

    typedef struct packed {
        logic [CORE_W-1:0] min_cores;
        logic [CORE_W-1:0] max_cores;
        logic [CORE_W-1:0] boost_cores;
        logic [HLEN_W-1:0] history_length;
        logic [LOCK_W-1:0] lock_duration;
        logic [THR_W-1:0]  up_thresholds;
        logic [THR_W-1:0]  down_thresholds;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [LOAD_W-1:0] load_sample;
        logic [CORE_W-1:0] online_count;
    } item_t;

    function automatic logic is_sample_kind(input kind_t k);
        return (k == K_PIN_MIN) || (k == K_PIN_MAX) || (k == K_BOOST) || (k == K_BANDS);
    endfunction

endpackage

// File: hdl/chlg_front.sv
// ----------------------------------------------------------------------------
// chlg_front
// Accepts items and sorts each into the rule that decides its request.
// ----------------------------------------------------------------------------
module chlg_front
    import chlg_pkg::*;
(
    input  cfg_t  cfg,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req,
    output logic  push,
    output item_t push_item,
    input  logic  full
);

    kind_t kind;

    // Pinned limits win over boost, boost over the load bands
    always_comb
    begin
        unique case (op_t'(req.op))
            OP_SAMPLE:
            begin
                if (cfg.min_cores == NUM_CORES_C)
                    kind = K_PIN_MIN;
                else if (cfg.max_cores == 4'd1)
                    kind = K_PIN_MAX;
                else if (req.boost_request && (req.online_count < cfg.boost_cores))
                    kind = K_BOOST;
                else
                    kind = K_BANDS;
            end
            OP_TICK:    kind = K_TICK;
            OP_SCR_OFF: kind = K_SCR_OFF;
            OP_SCR_ON:  kind = K_SCR_ON;
            default:    kind = K_TICK;
        endcase
    end

    assign req_stall              = full;
    assign push                   = req_valid && !full;
    assign push_item.kind         = kind;
    assign push_item.load_sample  = req.load_sample;
    assign push_item.online_count = req.online_count;

endmodule

// File: hdl/chlg_fifo.sv
// ----------------------------------------------------------------------------
// chlg_fifo
// Short item queue between the front and the back end.
// ----------------------------------------------------------------------------
module chlg_fifo
    import chlg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  empty
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: hdl/chlg_back.sv
// ----------------------------------------------------------------------------
// chlg_back
// Executes queued items: history ring, serial sum, serial divide, decision,
// down lock and the result register.
// ----------------------------------------------------------------------------
module chlg_back
    import chlg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  item_t head,
    input  logic  empty,
    output logic  pop,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp
);

    b_state_t              state_reg, state_next;
    item_t                 cur_reg, cur_next;
    logic [LOAD_W-1:0]     hist_reg [MAX_HISTORY];
    logic [LOAD_W-1:0]     hist_next [MAX_HISTORY];
    logic [HIST_IDX_W-1:0] hidx_reg, hidx_next;
    logic [HIST_IDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [NLEN_W-1:0]     rem_reg, rem_next;
    logic [LOAD_W-1:0]     avg_reg, avg_next;
    logic [LOCK_W-1:0]     lock_reg, lock_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic [NLEN_W-1:0]     n_eff, n_m1;
    logic [HIST_IDX_W-1:0] wr_idx;
    logic                  sum_last, div_last, out_free;
    logic [NLEN_W:0]       trial;
    logic                  ge;
    logic [SUM_W-1:0]      quot;
    logic [NLEN_W:0]       trial_sub;
    logic [CORE_W-1:0]     lvl_tgt, band_tgt;
    act_t                  dn_act, dec_act;
    logic [CORE_W-1:0]     dec_tgt;

    // History length zero acts as one, lengths past the ring saturate
    always_comb
    begin
        if (cfg.history_length == '0)
            n_eff = NLEN_W'(1);
        else if (NLEN_W'(cfg.history_length) > NLEN_W'(MAX_HISTORY))
            n_eff = NLEN_W'(MAX_HISTORY);
        else
            n_eff = NLEN_W'(cfg.history_length);
    end

    assign n_m1     = n_eff - 1'b1;
    assign wr_idx   = ({1'b0, hidx_reg} >= n_eff) ? '0 : hidx_reg;
    assign sum_last = (cnt_reg == CNT_W'(n_m1));
    assign div_last = (cnt_reg == CNT_W'(SUM_W - 1));
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // One restoring-divide step per cycle; quotient bits shift into sum_reg
    assign trial     = {rem_reg, sum_reg[SUM_W-1]};
    assign trial_sub = trial - {1'b0, n_eff};
    assign ge        = (trial >= {1'b0, n_eff});
    assign quot      = {sum_reg[SUM_W-2:0], ge};

    // Load bands: first level whose window holds the mean
    always_comb
    begin
        lvl_tgt = '0;
        for (int lvl = NUM_LEVELS - 1; lvl >= 1; lvl--)
        begin
            if ((avg_reg <= cfg.up_thresholds[LOAD_W*lvl +: LOAD_W]) &&
                (avg_reg >  cfg.down_thresholds[LOAD_W*lvl +: LOAD_W]))
                lvl_tgt = CORE_W'(lvl);
        end
        if (lvl_tgt > cfg.max_cores)
            band_tgt = cfg.max_cores;
        else if (lvl_tgt < cfg.min_cores)
            band_tgt = cfg.min_cores;
        else
            band_tgt = lvl_tgt;
    end

    assign dn_act = (lock_reg != '0) ? ACT_HELD : ACT_DOWN;

    always_comb
    begin
        dec_act = ACT_NONE;
        dec_tgt = '0;
        case (cur_reg.kind)
            K_PIN_MIN:
            begin
                dec_tgt = cfg.min_cores;
                if (cur_reg.online_count != dec_tgt)
                    dec_act = ACT_UP;
            end
            K_PIN_MAX:
            begin
                dec_tgt = cfg.max_cores;
                if (cur_reg.online_count != dec_tgt)
                    dec_act = dn_act;
            end
            K_BOOST:
            begin
                dec_tgt = cfg.boost_cores;
                dec_act = ACT_UP;
            end
            K_BANDS:
            begin
                dec_tgt = band_tgt;
                if (band_tgt > cur_reg.online_count)
                    dec_act = ACT_UP;
                else if (band_tgt < cur_reg.online_count)
                    dec_act = dn_act;
            end
            K_SCR_OFF:
            begin
                dec_tgt = 4'd1;
                dec_act = ACT_DOWN;
            end
            K_SCR_ON:
            begin
                dec_tgt = NUM_CORES_C;
                dec_act = ACT_UP;
            end
            default:
            begin
                dec_tgt = '0;
                dec_act = ACT_NONE;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                    state_next = is_sample_kind(head.kind) ? B_WRITE : B_DECIDE;
            end
            B_WRITE:  state_next = B_SUM;
            B_SUM:    state_next = sum_last ? B_DIV : B_SUM;
            B_DIV:    state_next = div_last ? B_DECIDE : B_DIV;
            B_DECIDE: state_next = out_free ? B_IDLE : B_DECIDE;
            default:  state_next = B_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        pop            = 1'b0;
        cur_next       = cur_reg;
        hist_next      = hist_reg;
        hidx_next      = hidx_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        avg_next       = avg_reg;
        lock_next      = lock_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                end
            end
            B_WRITE:
            begin
                hist_next[wr_idx] = cur_reg.load_sample;
                hidx_next = (({1'b0, wr_idx} + 1'b1) == n_eff) ? '0 : wr_idx + 1'b1;
                ptr_next  = wr_idx;
                cnt_next  = '0;
                sum_next  = '0;
            end
            B_SUM:
            begin
                sum_next = sum_reg + SUM_W'(hist_reg[ptr_reg]);
                ptr_next = (ptr_reg == '0) ? n_m1[HIST_IDX_W-1:0] : ptr_reg - 1'b1;
                cnt_next = sum_last ? '0 : cnt_reg + 1'b1;
                if (sum_last)
                    rem_next = '0;
            end
            B_DIV:
            begin
                rem_next = ge ? trial_sub[NLEN_W-1:0] : trial[NLEN_W-1:0];
                sum_next = quot;
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                    avg_next = quot[LOAD_W-1:0];
            end
            B_DECIDE:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.action      = dec_act;
                    rsp_next.target_cores = dec_tgt;
                    rsp_next.average_load = avg_reg;
                    if (dec_act == ACT_UP)
                        lock_next = cfg.lock_duration;
                    else if (cur_reg.kind == K_SCR_OFF)
                        lock_next = '0;
                    else if ((cur_reg.kind == K_TICK) && (lock_reg != '0))
                        lock_next = lock_reg - 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            hidx_reg      <= '0;
            avg_reg       <= '0;
            lock_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_HISTORY; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hidx_reg      <= hidx_next;
            avg_reg       <= avg_next;
            lock_reg      <= lock_next;
            rsp_valid_reg <= rsp_valid_next;
            hist_reg      <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ptr_reg <= ptr_next;
        cnt_reg <= cnt_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Ring index always stays inside the active length after a write
    a_hidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WRITE) |=> ({1'b0, hidx_reg} < n_eff))
        else $error("history index outside active length");

    // Divider remainder stays below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (rem_reg < n_eff))
        else $error("divider remainder out of range");

    // Mean changes only on the last divide step
    a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == B_DIV && div_last) |=> $stable(avg_reg))
        else $error("average changed outside divide completion");

    // An up request reloads the down lock
    a_lock_arm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DECIDE && out_free && dec_act == ACT_UP)
        |=> (lock_reg == $past(cfg.lock_duration)))
        else $error("down lock not armed by up request");

endmodule

// File: hdl/cpu_hotplug_load_governor.sv
// ----------------------------------------------------------------------------
// cpu_hotplug_load_governor
// Decides the online core count from averaged load, with down lock.
// ----------------------------------------------------------------------------
// A load-sample item goes from the queue through the write, sum, divide and
// decide states, with n the effective history length (1 to 16): the back end
// walks the history registers one entry a cycle to form the sum of n entries
// and then runs a bit-serial divider of 16 steps. Tick and screen items go
// straight to the decide state. Up to two items wait in the queue while the
// back end is busy, and the result register lets the next item start while a
// result is stalled. The history ring is cleared by reset itself, with no
// clearing pass. Registers sit at byte address 8*i on a 64-bit APB port;
// write them only while no item is in flight.
module cpu_hotplug_load_governor
    import chlg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     cfg_wr;
    logic     push, full, pop, empty;
    item_t    push_item, head;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_MIN_CORES:   cfg_next.min_cores       = pwdata[CORE_W-1:0];
                REG_MAX_CORES:   cfg_next.max_cores       = pwdata[CORE_W-1:0];
                REG_BOOST_CORES: cfg_next.boost_cores     = pwdata[CORE_W-1:0];
                REG_HIST_LEN:    cfg_next.history_length  = pwdata[HLEN_W-1:0];
                REG_LOCK_DUR:    cfg_next.lock_duration   = pwdata[LOCK_W-1:0];
                REG_UP_THR:      cfg_next.up_thresholds   = pwdata[THR_W-1:0];
                REG_DOWN_THR:    cfg_next.down_thresholds = pwdata[THR_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_CORES:   prdata = APB_DATA_W'(cfg_reg.min_cores);
            REG_MAX_CORES:   prdata = APB_DATA_W'(cfg_reg.max_cores);
            REG_BOOST_CORES: prdata = APB_DATA_W'(cfg_reg.boost_cores);
            REG_HIST_LEN:    prdata = APB_DATA_W'(cfg_reg.history_length);
            REG_LOCK_DUR:    prdata = APB_DATA_W'(cfg_reg.lock_duration);
            REG_UP_THR:      prdata = APB_DATA_W'(cfg_reg.up_thresholds);
            REG_DOWN_THR:    prdata = APB_DATA_W'(cfg_reg.down_thresholds);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_cores       <= MIN_CORES_RST;
            cfg_reg.max_cores       <= MAX_CORES_RST;
            cfg_reg.boost_cores     <= BOOST_CORES_RST;
            cfg_reg.history_length  <= HIST_LEN_RST;
            cfg_reg.lock_duration   <= LOCK_DUR_RST;
            cfg_reg.up_thresholds   <= UP_THR_RST;
            cfg_reg.down_thresholds <= DOWN_THR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    chlg_front u_front
    (
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    chlg_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    chlg_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// File: tb/sv/hotplug_decision_check.sv
// ----------------------------------------------------------------------------
// hotplug_decision_check
// Watches the register port and both item channels of the hotplug load
// governor. It keeps its own copy of the registers, the load ring and the
// down lock, predicts the decision for every accepted item and compares it
// with the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hotplug_decision_check
    import chlg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  req_t                  req,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  rsp_t                  rsp,
    output int                    mismatches,
    output int                    decisions_pending,
    output int                    decisions_checked
);

    cfg_t              cfg;
    logic [LOAD_W-1:0] load_ring [MAX_HISTORY];
    int unsigned       ring_pos;
    logic [LOCK_W-1:0] lock_left;
    logic [LOAD_W-1:0] mean_load;
    rsp_t              expected_decisions [$];
    rsp_t              want;
    int                errs;
    int                seen;

    function automatic act_t request_up();
        lock_left = cfg.lock_duration;
        return ACT_UP;
    endfunction

    function automatic act_t request_down();
        if (lock_left != '0)
        begin
            return ACT_HELD;
        end
        return ACT_DOWN;
    endfunction

    function automatic void write_setting(logic [2:0] idx, logic [APB_DATA_W-1:0] v);
        case (reg_idx_t'(idx))
            REG_MIN_CORES:   cfg.min_cores       = v[CORE_W-1:0];
            REG_MAX_CORES:   cfg.max_cores       = v[CORE_W-1:0];
            REG_BOOST_CORES: cfg.boost_cores     = v[CORE_W-1:0];
            REG_HIST_LEN:    cfg.history_length  = v[HLEN_W-1:0];
            REG_LOCK_DUR:    cfg.lock_duration   = v[LOCK_W-1:0];
            REG_UP_THR:      cfg.up_thresholds   = v[THR_W-1:0];
            REG_DOWN_THR:    cfg.down_thresholds = v[THR_W-1:0];
            default:         ;
        endcase
    endfunction

    // Decision for one item; updates ring, mean and lock as the block does
    function automatic rsp_t decide_cores(req_t r);
        rsp_t              d;
        int unsigned       n;
        int unsigned       sum;
        int unsigned       lvl;
        int unsigned       k;
        logic              found;
        logic [LOAD_W-1:0] hi;
        logic [LOAD_W-1:0] lo;
        logic [CORE_W-1:0] goal;
        act_t              act;
        act  = ACT_NONE;
        goal = '0;
        case (op_t'(r.op))
            OP_SAMPLE:
            begin
                n = 32'(cfg.history_length);
                if (n == 0)
                begin
                    n = 1;
                end
                if (n > MAX_HISTORY)
                begin
                    n = MAX_HISTORY;
                end
                // a shortened history can leave the write slot out of range
                if (ring_pos >= n)
                begin
                    ring_pos = 0;
                end
                load_ring[ring_pos[HIST_IDX_W-1:0]] = r.load_sample;
                sum = 0;
                for (k = 0; k < n; k++)
                begin
                    sum += 32'(load_ring[k[HIST_IDX_W-1:0]]);
                end
                ring_pos  = (ring_pos + 1 == n) ? 0 : ring_pos + 1;
                mean_load = LOAD_W'(sum / n);

                if (cfg.min_cores == NUM_CORES_C)
                begin
                    goal = cfg.min_cores;
                    if (r.online_count != goal)
                    begin
                        act = request_up();
                    end
                end
                else if (cfg.max_cores == CORE_W'(1))
                begin
                    goal = cfg.max_cores;
                    if (r.online_count != goal)
                    begin
                        act = request_down();
                    end
                end
                else if (r.boost_request && r.online_count < cfg.boost_cores)
                begin
                    goal = cfg.boost_cores;
                    act  = request_up();
                end
                else
                begin
                    found = 1'b0;
                    for (lvl = 1; lvl < NUM_LEVELS; lvl++)
                    begin
                        hi = cfg.up_thresholds[LOAD_W*lvl +: LOAD_W];
                        lo = cfg.down_thresholds[LOAD_W*lvl +: LOAD_W];
                        if (!found && mean_load <= hi && mean_load > lo)
                        begin
                            goal  = CORE_W'(lvl);
                            found = 1'b1;
                        end
                    end
                    if (goal > cfg.max_cores)
                    begin
                        goal = cfg.max_cores;
                    end
                    else if (goal < cfg.min_cores)
                    begin
                        goal = cfg.min_cores;
                    end
                    if (goal > r.online_count)
                    begin
                        act = request_up();
                    end
                    else if (goal < r.online_count)
                    begin
                        act = request_down();
                    end
                end
            end
            OP_TICK:
            begin
                if (lock_left != '0)
                begin
                    lock_left = lock_left - 1'b1;
                end
            end
            OP_SCR_OFF:
            begin
                lock_left = '0;
                goal      = CORE_W'(1);
                act       = ACT_DOWN;
            end
            default:
            begin
                goal = NUM_CORES_C;
                act  = request_up();
            end
        endcase
        d.action       = act;
        d.target_cores = goal;
        d.average_load = mean_load;
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.min_cores       = MIN_CORES_RST;
            cfg.max_cores       = MAX_CORES_RST;
            cfg.boost_cores     = BOOST_CORES_RST;
            cfg.history_length  = HIST_LEN_RST;
            cfg.lock_duration   = LOCK_DUR_RST;
            cfg.up_thresholds   = UP_THR_RST;
            cfg.down_thresholds = DOWN_THR_RST;
            foreach (load_ring[i])
            begin
                load_ring[i] = '0;
            end
            ring_pos  = 0;
            lock_left = '0;
            mean_load = '0;
            expected_decisions.delete();
            errs = 0;
            seen = 0;
            mismatches        <= 0;
            decisions_pending <= 0;
            decisions_checked <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                write_setting(paddr[PADDR_W-1:3], pwdata);
            end
            // results first: none can belong to an item taken at this edge
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_decisions.size() == 0)
                begin
                    errs++;
                    $error("unexpected result: action %0d target %0d average %0d",
                           rsp.action, rsp.target_cores, rsp.average_load);
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    seen++;
                    if (rsp.action !== want.action)
                    begin
                        errs++;
                        $error("action: expected %0d, got %0d", want.action, rsp.action);
                    end
                    if (rsp.target_cores !== want.target_cores)
                    begin
                        errs++;
                        $error("target_cores: expected %0d, got %0d",
                               want.target_cores, rsp.target_cores);
                    end
                    if (rsp.average_load !== want.average_load)
                    begin
                        errs++;
                        $error("average_load: expected %0d, got %0d",
                               want.average_load, rsp.average_load);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                expected_decisions.push_back(decide_cores(req));
            end
            mismatches        <= errs;
            decisions_pending <= expected_decisions.size();
            decisions_checked <= seen;
        end
    end

endmodule

// File: tb/sv/cpu_hotplug_load_governor_test.sv
// ----------------------------------------------------------------------------
// cpu_hotplug_load_governor_test
// Drives the hotplug load governor with a short directed run at reset
// settings, then random load, tick and screen items under a series of
// register settings and pacing modes. The decision checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cpu_hotplug_load_governor_test;
    import chlg_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 140;
    localparam int SETTLE      = 60;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [PADDR_W-1:0]    paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;

    int mismatches;
    int decisions_pending;
    int decisions_checked;

    int                send_idle_pct = 0;
    int                stall_pct     = 0;
    int                items_sent    = 0;
    int                directed_sent = 0;
    logic [LOAD_W-1:0] band_top      = 12'd410;

    cpu_hotplug_load_governor dut (.*);

    hotplug_decision_check decision_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic req_t mk(op_t op, int load, int online, bit boost);
        req_t r;
        r.op            = op;
        r.load_sample   = LOAD_W'(load);
        r.online_count  = CORE_W'(online);
        r.boost_request = boost;
        return r;
    endfunction

    function automatic req_t random_item();
        int   pick;
        op_t  op;
        int   load;
        int   online;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            op = OP_SAMPLE;
        end
        else if (pick < 85)
        begin
            op = OP_TICK;
        end
        else if (pick < 92)
        begin
            op = OP_SCR_OFF;
        end
        else
        begin
            op = OP_SCR_ON;
        end
        // half the loads land under the top band so the averages hit bands
        load   = $urandom_range(1) ? $urandom_range(4095) : $urandom_range(band_top);
        online = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8);
        return mk(op, load, online, 1'($urandom_range(1)));
    endfunction

    // Bands stacked upward: level i spans (cut[i-1], cut[i]]
    function automatic void random_bands(output logic [THR_W-1:0] up,
                                         output logic [THR_W-1:0] dn);
        int cut [5];
        cut[0] = $urandom_range(200);
        for (int i = 1; i < 5; i++)
        begin
            cut[i] = cut[i-1] + $urandom_range(1, 800);
            if (cut[i] > 4095)
            begin
                cut[i] = 4095;
            end
        end
        up[LOAD_W-1:0] = LOAD_W'($urandom_range(4095));
        dn[LOAD_W-1:0] = LOAD_W'($urandom_range(4095));
        for (int i = 1; i < 5; i++)
        begin
            up[LOAD_W*i +: LOAD_W] = LOAD_W'(cut[i]);
            // occasional overlap with the band below
            dn[LOAD_W*i +: LOAD_W] = LOAD_W'($urandom_range(3) == 0 ?
                                             cut[i-1] / 2 : cut[i-1]);
        end
    endfunction

    function automatic cfg_t pick_setting(int p);
        cfg_t              c;
        logic [THR_W-1:0]  up;
        logic [THR_W-1:0]  dn;
        random_bands(up, dn);
        c.up_thresholds   = up;
        c.down_thresholds = dn;
        c.lock_duration   = LOCK_W'($urandom_range(40));
        case (p)
            1:
            begin
                c.min_cores = 4'd1; c.max_cores = 4'd8; c.boost_cores = 4'd8;
                c.history_length = 5'd1; c.lock_duration = '0;
            end
            2:
            begin
                // min pinned at the full core count
                c.min_cores = 4'd4; c.max_cores = 4'd8; c.boost_cores = 4'd3;
                c.history_length = 5'd16; c.lock_duration = 16'd5;
            end
            3:
            begin
                // max pinned at one core
                c.min_cores = 4'd1; c.max_cores = 4'd1; c.boost_cores = 4'd0;
                c.history_length = 5'd7; c.lock_duration = 16'd3;
            end
            4:
            begin
                c.min_cores = 4'd2; c.max_cores = 4'd6; c.boost_cores = 4'd5;
                c.history_length = 5'd16; c.lock_duration = 16'hFFFF;
                c.up_thresholds = '1; c.down_thresholds = '0;
            end
            5:
            begin
                // zero history length acts as one; write slot wraps
                c.min_cores = 4'd0; c.max_cores = 4'd15; c.boost_cores = 4'd15;
                c.history_length = 5'd0;
            end
            6:
            begin
                c.min_cores = 4'd15; c.max_cores = 4'd3; c.boost_cores = 4'd1;
                c.history_length = 5'd31;
                c.up_thresholds = '0; c.down_thresholds = '1;
            end
            7:
            begin
                c.min_cores = MIN_CORES_RST; c.max_cores = MAX_CORES_RST;
                c.boost_cores = BOOST_CORES_RST; c.history_length = HIST_LEN_RST;
                c.lock_duration = LOCK_DUR_RST;
                c.up_thresholds = UP_THR_RST; c.down_thresholds = DOWN_THR_RST;
            end
            default:
            begin
                c.min_cores = CORE_W'($urandom_range(1, 8));
                c.max_cores = CORE_W'($urandom_range(1, 8));
                c.boost_cores = CORE_W'($urandom_range(8));
                c.history_length = HLEN_W'($urandom_range(1, 16));
            end
        endcase
        return c;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic program_governor(cfg_t c);
        write_reg(REG_MIN_CORES,   APB_DATA_W'(c.min_cores));
        write_reg(REG_MAX_CORES,   APB_DATA_W'(c.max_cores));
        write_reg(REG_BOOST_CORES, APB_DATA_W'(c.boost_cores));
        write_reg(REG_HIST_LEN,    APB_DATA_W'(c.history_length));
        write_reg(REG_LOCK_DUR,    APB_DATA_W'(c.lock_duration));
        write_reg(REG_UP_THR,      APB_DATA_W'(c.up_thresholds));
        write_reg(REG_DOWN_THR,    APB_DATA_W'(c.down_thresholds));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        band_top = c.up_thresholds[THR_W-1 -: LOAD_W];
        if (band_top < 12'd16)
        begin
            band_top = 12'hFFF;
        end
    endtask

    // valid stays high after acceptance until an idle pause in the next call or the drain lowers it
    task automatic send_item(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        items_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (decisions_pending != 0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: bands 50/100/150/410 over 0/40/80/140, lock 2000
        send_item(mk(OP_SAMPLE, 0, 0, 1'b0));
        send_item(mk(OP_TICK, 4095, 15, 1'b1));
        send_item(mk(OP_SCR_OFF, 0, 0, 1'b0));
        send_item(mk(OP_SAMPLE, 4095, 8, 1'b1));
        send_item(mk(OP_SAMPLE, 4095, 15, 1'b0));
        send_item(mk(OP_SAMPLE, 0, 2, 1'b1));
        send_item(mk(OP_SAMPLE, 500, 0, 1'b1));
        send_item(mk(OP_SAMPLE, 500, 1, 1'b1));
        send_item(mk(OP_SCR_ON, 4095, 0, 1'b1));
        send_item(mk(OP_SAMPLE, 0, 4, 1'b0));
        send_item(mk(OP_TICK, 0, 0, 1'b0));
        send_item(mk(OP_TICK, 0, 8, 1'b0));
        send_item(mk(OP_SCR_OFF, 4095, 15, 1'b1));
        send_item(mk(OP_SAMPLE, 0, 4, 1'b0));
        send_item(mk(OP_SAMPLE, 50, 1, 1'b0));
        send_item(mk(OP_SAMPLE, 100, 2, 1'b0));
        send_item(mk(OP_SAMPLE, 150, 3, 1'b0));
        send_item(mk(OP_SAMPLE, 410, 4, 1'b0));
        send_item(mk(OP_SAMPLE, 411, 0, 1'b0));
        send_item(mk(OP_SCR_ON, 0, 4, 1'b0));
        send_item(mk(OP_SAMPLE, 2048, 1, 1'b0));
        send_item(mk(OP_SCR_OFF, 0, 8, 1'b0));
        directed_sent = items_sent;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 81; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            if (p != 0)
            begin
                program_governor(pick_setting(p));
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_item(random_item());
            end
        end
        wait_drained();
        stall_pct = 0;
        repeat (SETTLE) @(posedge clk);

        $display("%0d items (%0d directed) over %0d register settings, four pacing modes",
                 items_sent, directed_sent, PHASES);
        $display("%0d decisions compared, %0d mismatching fields",
                 decisions_checked, mismatches);
        if (mismatches == 0 && decisions_pending == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: cpu_hotplug_load_governor.f
hdl/chlg_pkg.sv
hdl/chlg_front.sv
hdl/chlg_fifo.sv
hdl/chlg_back.sv
hdl/cpu_hotplug_load_governor.sv
tb/sv/hotplug_decision_check.sv
tb/sv/cpu_hotplug_load_governor_test.sv
